// ----- src/typed_watch_value_comparator_unit_defines.svh -----
// assertion macros for the typed watch value comparator
// no dependencies; define NO_ASSERTIONS to compile them away
`ifndef TYPED_WATCH_VALUE_COMPARATOR_UNIT_DEFINES_SVH
`define TYPED_WATCH_VALUE_COMPARATOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TWVC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define TWVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define TWVC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TWVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- src/twvc_pkg.sv -----
// package for the typed watch value comparator
// types and codes shared by the compare core and the top level
package twvc_pkg;
	localparam int unsigned ValueW = 64;
	localparam int unsigned CfgIdxW = 2;

	typedef enum logic [2:0] {
		TYPE_U32 = 3'd0,
		TYPE_S32 = 3'd1,
		TYPE_U64 = 3'd2,
		TYPE_S64 = 3'd3,
		TYPE_F64 = 3'd4
	} value_type_t;

	typedef enum logic [2:0] {
		OP_EQ = 3'd0,
		OP_GT = 3'd1,
		OP_LT = 3'd2,
		OP_GE = 3'd3,
		OP_LE = 3'd4
	} compare_op_t;

	localparam logic [CfgIdxW-1:0] REG_VALUE_TYPE = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_COMPARE_OP = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_THRESHOLD  = 2'd2;

	typedef struct packed {
		logic [2:0]        value_type;
		logic [2:0]        compare_op;
		logic [ValueW-1:0] threshold;
	} cfg_t;
endpackage

// ----- src/twvc_core.sv -----
// compare core: one registered pass from value and config to match
// depends on twvc_pkg
module twvc_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [twvc_pkg::ValueW-1:0] value,
	input  twvc_pkg::cfg_t              cfg,
	output logic                        match
);
	logic [63:0] a;
	logic [63:0] b;
	logic        nan_any;
	logic        valid_type;
	logic        eq;
	logic        lt;
	logic        m;
	logic        m_s2;

	function automatic logic [63:0] f64_key(input logic [63:0] x);
		logic [63:0] y;
		y = (x == 64'h8000_0000_0000_0000) ? 64'd0 : x;
		return y[63] ? ~y : (y ^ 64'h8000_0000_0000_0000);
	endfunction

	function automatic logic is_nan(input logic [63:0] x);
		return (x[62:52] == 11'h7ff) && (x[51:0] != 52'd0);
	endfunction

	// map both operands to unsigned order keys
	always_comb begin
		a = 64'd0;
		b = 64'd0;
		valid_type = 1'b1;
		nan_any = 1'b0;
		unique case (cfg.value_type)
			twvc_pkg::TYPE_U32: begin
				a = {32'd0, value[31:0]};
				b = {32'd0, cfg.threshold[31:0]};
			end
			twvc_pkg::TYPE_S32: begin
				a = {32'd0, ~value[31], value[30:0]};
				b = {32'd0, ~cfg.threshold[31], cfg.threshold[30:0]};
			end
			twvc_pkg::TYPE_U64: begin
				a = value;
				b = cfg.threshold;
			end
			twvc_pkg::TYPE_S64: begin
				a = {~value[63], value[62:0]};
				b = {~cfg.threshold[63], cfg.threshold[62:0]};
			end
			twvc_pkg::TYPE_F64: begin
				a = f64_key(value);
				b = f64_key(cfg.threshold);
				nan_any = is_nan(value) || is_nan(cfg.threshold);
			end
			default: valid_type = 1'b0;
		endcase
	end

	// relation select
	always_comb begin
		eq = (a == b);
		lt = (a < b);
		unique case (cfg.compare_op)
			twvc_pkg::OP_EQ: m = eq;
			twvc_pkg::OP_GT: m = !eq && !lt;
			twvc_pkg::OP_LT: m = lt;
			twvc_pkg::OP_GE: m = !lt;
			twvc_pkg::OP_LE: m = lt || eq;
			default:         m = 1'b0;
		endcase
		m = m && valid_type && !nan_any;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_s2 <= 1'b0;
		end else if (en) begin
			m_s2 <= m;
		end
	end

	assign match = m_s2;
endmodule

// ----- src/typed_watch_value_comparator_unit.sv -----
// Typed watch value comparator. Each accepted item on s_axis (64-bit value) yields one
// item on m_axis (match in bit 0) telling whether "value OP threshold" holds in the type set by
// cfg register 0 (0 u32, 1 s32, 2 u64, 3 s64, 4 binary64), OP by register 1 (eq, gt, lt, ge, le)
// and threshold by register 2. One item per cycle sustained while m_axis_tready is high; each
// item goes through an input register then one compare pass into the output register. NaN
// never matches, -0 equals +0, unknown type or operator gives 0. Write config only while idle.
`include "typed_watch_value_comparator_unit_defines.svh"
module typed_watch_value_comparator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [twvc_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [63:0]                  cfg_data,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [63:0]                  s_axis_tdata,  // [63:0] value
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [7:0]                   m_axis_tdata   // [0] match, [7:1] zero
);
	twvc_pkg::cfg_t cfg_q;
	logic [63:0]    value_s1;
	logic           valid_s1;
	logic           valid_s2;
	logic           adv;
	logic           take;
	logic           match;

	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == twvc_pkg::REG_VALUE_TYPE) cfg_q.value_type <= cfg_data[2:0];
			if (cfg_index == twvc_pkg::REG_COMPARE_OP) cfg_q.compare_op <= cfg_data[2:0];
			if (cfg_index == twvc_pkg::REG_THRESHOLD)  cfg_q.threshold  <= cfg_data;
		end
	end

	// pipeline flow: stage 2 advances when empty or taken
	assign adv = !valid_s2 || m_axis_tready;
	assign s_axis_tready = adv || !valid_s1;
	assign take = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv) valid_s2 <= valid_s1;
			if (s_axis_tready) valid_s1 <= s_axis_tvalid;
		end
	end

	// input register
	always_ff @(posedge clk) begin
		if (take) value_s1 <= s_axis_tdata;
	end

	twvc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv && valid_s1),
		.value  (value_s1),
		.cfg    (cfg_q),
		.match  (match)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {7'd0, match};

	`TWVC_ASSERT_NEXT(a_hold_out, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`TWVC_ASSERT_NEXT(a_flow, clk, arst_n, valid_s1 && adv, valid_s2)
	`TWVC_ASSERT_IMPL(a_ready, clk, arst_n, !valid_s1, s_axis_tready)
endmodule
